@@ hw/rtl/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg: polynomial token scanner shared definitions
// Token kinds, scanner modes, character codes and the result bundle types.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    localparam int POS_WIDTH_DEFAULT = 16;
    localparam int OUT_POS_W         = 16;
    localparam int MAX_RESULTS       = 3;
    localparam int QUEUE_DEPTH       = 4;

    typedef enum logic [2:0] {
        KIND_LPAREN = 3'd0,
        KIND_RPAREN = 3'd1,
        KIND_PLUS   = 3'd2,
        KIND_MINUS  = 3'd3,
        KIND_STAR   = 3'd4,
        KIND_MONO   = 3'd5,
        KIND_END    = 3'd6,
        KIND_ERROR  = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_INT   = 3'd1,
        MODE_FRAC  = 3'd2,
        MODE_VAR   = 3'd3,
        MODE_CARET = 3'd4,
        MODE_EXP   = 3'd5,
        MODE_DROP  = 3'd6
    } mode_t;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        kind_t                  kind;
        logic [OUT_POS_W-1:0]   start_pos;
        logic [OUT_POS_W-1:0]   end_pos;
    } token_t;

    // All tokens caused by one character, oldest in slot 0.
    typedef struct packed {
        logic [1:0]                    count;
        token_t [MAX_RESULTS-1:0]      tok;
    } batch_t;

endpackage : pts_pkg

`default_nettype wire

@@ hw/rtl/pts_in_if.sv @@
// ----------------------------------------------------------------------------
// pts_in_if: character channel
// valid/ready channel carrying one source character and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface : pts_in_if

`default_nettype wire

@@ hw/rtl/pts_out_if.sv @@
// ----------------------------------------------------------------------------
// pts_out_if: token channel
// valid/ready channel carrying one token with its positions.
// ----------------------------------------------------------------------------
`default_nettype none

interface pts_out_if;
    logic                          valid;
    logic                          ready;
    pts_pkg::kind_t                kind;
    logic [pts_pkg::OUT_POS_W-1:0] start_pos;
    logic [pts_pkg::OUT_POS_W-1:0] end_pos;
    logic                          run_last;

    modport source (output valid, output kind, output start_pos, output end_pos,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input start_pos, input end_pos,
                    input run_last, output ready);
endinterface : pts_out_if

`default_nettype wire

@@ hw/rtl/pts_core.sv @@
// ----------------------------------------------------------------------------
// pts_core: scanner next-state logic
// Single pass over one character: closes a pending monomial, rescans from
// idle, flags errors, appends end-of-source, and returns up to three tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_core #(
    parameter int POS_WIDTH = pts_pkg::POS_WIDTH_DEFAULT
) (
    input  pts_pkg::mode_t       mode,
    input  logic [POS_WIDTH-1:0] pos,
    input  logic [POS_WIDTH-1:0] tstart,
    input  logic [7:0]           char_code,
    input  logic                 last_char,
    output pts_pkg::mode_t       mode_next,
    output logic [POS_WIDTH-1:0] pos_next,
    output logic [POS_WIDTH-1:0] tstart_next,
    output pts_pkg::batch_t      batch
);
    import pts_pkg::*;

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    function automatic logic [OUT_POS_W-1:0] out_pos(input logic [POS_WIDTH-1:0] v);
        logic [POS_WIDTH+OUT_POS_W-1:0] ext;
        ext = {{OUT_POS_W{1'b0}}, v};
        return ext[OUT_POS_W-1:0];
    endfunction

    function automatic token_t mk_tok(input kind_t k, input logic [POS_WIDTH-1:0] s,
                                      input logic [POS_WIDTH-1:0] e);
        token_t t;
        t.kind      = k;
        t.start_pos = out_pos(s);
        t.end_pos   = out_pos(e);
        return t;
    endfunction

    logic is_ws;
    logic is_digit;
    logic [POS_WIDTH-1:0] pos_inc;

    assign is_ws    = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign pos_inc  = pos + {{(POS_WIDTH-1){1'b0}}, 1'b1};

    always_comb
    begin
        mode_t      m;
        logic [POS_WIDTH-1:0] ts;
        logic       rescan;
        logic [1:0] n;
        token_t [MAX_RESULTS-1:0] tok;

        m      = mode;
        ts     = tstart;
        rescan = 1'b0;
        n      = 2'd0;
        tok    = '0;

        if (mode == MODE_DROP)
        begin
            // input ignored until the last character
        end
        else if (pos == POS_MAX)
        begin
            // position saturated: error, pending monomial discarded
            tok[n] = mk_tok(KIND_ERROR,
                            (mode != MODE_IDLE) ? tstart : POS_MAX, POS_MAX);
            n = n + 2'd1;
            m = MODE_DROP;
        end
        else
        begin
            case (mode)
                MODE_IDLE:
                begin
                    rescan = 1'b1;
                end
                MODE_INT, MODE_FRAC:
                begin
                    if (is_digit)
                    begin
                    end
                    else if (char_code == CH_DOT && mode == MODE_INT)
                        m = MODE_FRAC;
                    else if (char_code == CH_X)
                        m = MODE_VAR;
                    else
                    begin
                        tok[n] = mk_tok(KIND_MONO, tstart, pos);
                        n = n + 2'd1;
                        rescan = 1'b1;
                    end
                end
                MODE_VAR:
                begin
                    if (char_code == CH_CARET)
                        m = MODE_CARET;
                    else
                    begin
                        tok[n] = mk_tok(KIND_MONO, tstart, pos);
                        n = n + 2'd1;
                        rescan = 1'b1;
                    end
                end
                MODE_CARET:
                begin
                    if (is_ws)
                    begin
                        tok[n] = mk_tok(KIND_ERROR, tstart, pos_inc);
                        n = n + 2'd1;
                        m = MODE_DROP;
                    end
                    else if (is_digit)
                        m = MODE_EXP;
                    else
                    begin
                        tok[n] = mk_tok(KIND_MONO, tstart, pos);
                        n = n + 2'd1;
                        rescan = 1'b1;
                    end
                end
                MODE_EXP:
                begin
                    if (!is_digit)
                    begin
                        tok[n] = mk_tok(KIND_MONO, tstart, pos);
                        n = n + 2'd1;
                        rescan = 1'b1;
                    end
                end
                default:
                begin
                    m = MODE_DROP;
                end
            endcase

            // same character scanned again from idle
            if (rescan)
            begin
                m = MODE_IDLE;
                if (is_ws)
                begin
                end
                else if (char_code == CH_LPAREN)
                begin
                    tok[n] = mk_tok(KIND_LPAREN, pos, pos_inc);
                    n = n + 2'd1;
                end
                else if (char_code == CH_RPAREN)
                begin
                    tok[n] = mk_tok(KIND_RPAREN, pos, pos_inc);
                    n = n + 2'd1;
                end
                else if (char_code == CH_PLUS)
                begin
                    tok[n] = mk_tok(KIND_PLUS, pos, pos_inc);
                    n = n + 2'd1;
                end
                else if (char_code == CH_MINUS)
                begin
                    tok[n] = mk_tok(KIND_MINUS, pos, pos_inc);
                    n = n + 2'd1;
                end
                else if (char_code == CH_STAR)
                begin
                    tok[n] = mk_tok(KIND_STAR, pos, pos_inc);
                    n = n + 2'd1;
                end
                else if (char_code == CH_X)
                begin
                    ts = pos;
                    m  = MODE_VAR;
                end
                else if (is_digit)
                begin
                    ts = pos;
                    m  = MODE_INT;
                end
                else if (char_code == CH_DOT)
                begin
                    ts = pos;
                    m  = MODE_FRAC;
                end
                else
                begin
                    tok[n] = mk_tok(KIND_ERROR, pos, pos_inc);
                    n = n + 2'd1;
                    m = MODE_DROP;
                end
            end

            if (last_char && m != MODE_DROP)
            begin
                if (m != MODE_IDLE)
                begin
                    tok[n] = mk_tok(KIND_MONO, ts, pos_inc);
                    n = n + 2'd1;
                end
                tok[n] = mk_tok(KIND_END, pos_inc, pos_inc);
                n = n + 2'd1;
            end
        end

        if (last_char)
        begin
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            tstart_next = '0;
        end
        else
        begin
            mode_next   = m;
            tstart_next = ts;
            pos_next    = (pos == POS_MAX) ? pos : pos_inc;
        end

        batch.count = n;
        batch.tok   = tok;
    end

endmodule : pts_core

`default_nettype wire

@@ hw/rtl/pts_result_queue.sv @@
// ----------------------------------------------------------------------------
// pts_result_queue: token output queue
// Takes a batch of up to three tokens per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_result_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pts_pkg::batch_t batch,
    output logic            has_room,
    pts_out_if.source       token_out
);
    import pts_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t              tok_reg  [QUEUE_DEPTH];
    logic                last_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [1:0]          n_push;
    logic                pop;

    assign n_push   = push ? batch.count : 2'd0;
    assign pop      = token_out.valid && token_out.ready;
    // room for a full batch
    assign has_room = (count_reg <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (i < int'(n_push))
            begin
                tok_reg[wr_ptr_reg + PTR_W'(i)]  <= batch.tok[i];
                last_reg[wr_ptr_reg + PTR_W'(i)] <= (i == int'(n_push) - 1);
            end
        end
    end

    assign token_out.valid     = (count_reg != '0);
    assign token_out.kind      = tok_reg[rd_ptr_reg].kind;
    assign token_out.start_pos = tok_reg[rd_ptr_reg].start_pos;
    assign token_out.end_pos   = tok_reg[rd_ptr_reg].end_pos;
    assign token_out.run_last  = last_reg[rd_ptr_reg];

endmodule : pts_result_queue

`default_nettype wire

@@ hw/rtl/polynomial_token_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// polynomial_token_scanner_unit: polynomial expression tokenizer
// Splits a character stream into paren, operator, monomial, end and error
// tokens, each tagged with start and end character positions.
// ----------------------------------------------------------------------------
//
//   channel     dir   payload                                   handshake
//   char_in     in    char_code[7:0], last_char                 valid/ready
//   token_out   out   kind[2:0], start_pos, end_pos, run_last   valid/ready
//
// Flow: a character is scanned in the cycle of its transfer; its tokens
//   (zero to three) are registered in the result queue and leave token_out
//   one per transfer. With one token per character and token_out always
//   ready the unit sustains one character per clock; a character with more
//   than one token keeps the single token output port busy for each of them.
// Stalls: char_in is ready while the 4-entry result queue has room for a
//   full batch of three tokens, so input keeps moving while a token waits.
// Reset: rst_n clears scanner mode, position and the queue; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_token_scanner_unit #(
    parameter int POS_WIDTH = pts_pkg::POS_WIDTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    pts_in_if.sink    char_in,
    pts_out_if.source token_out
);
    import pts_pkg::*;

    // scanner state, advanced on each character transfer
    mode_t                mode_reg;
    mode_t                mode_next;
    logic [POS_WIDTH-1:0] pos_reg;
    logic [POS_WIDTH-1:0] pos_next;
    logic [POS_WIDTH-1:0] tstart_reg;
    logic [POS_WIDTH-1:0] tstart_next;

    batch_t batch;
    logic   has_room;
    logic   accept;

    assign char_in.ready = has_room;
    assign accept        = char_in.valid && has_room;

    // one pass: close pending monomial, rescan, append end token
    pts_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .mode        (mode_reg),
        .pos         (pos_reg),
        .tstart      (tstart_reg),
        .char_code   (char_in.char_code),
        .last_char   (char_in.last_char),
        .mode_next   (mode_next),
        .pos_next    (pos_next),
        .tstart_next (tstart_next),
        .batch       (batch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
        end
    end

    // tokens wait here; the last one of each character carries run_last
    pts_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .batch     (batch),
        .has_room  (has_room),
        .token_out (token_out)
    );

endmodule : polynomial_token_scanner_unit

`default_nettype wire

@@ tb/polynomial_token_scanner_unit_tb.sv @@
// ----------------------------------------------------------------------------
// polynomial_token_scanner_unit_tb: self-checking bench for the token scanner
// Streams source texts (directed, random expressions, noise) through char_in
// and checks every token on token_out against a cycle-free scanner predictor,
// under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module polynomial_token_scanner_unit_tb;

    import pts_pkg::*;

    localparam int          LIMIT_CYCLES = 200_000;
    localparam int          RANDOM_CHARS = 390;
    localparam logic [15:0] POS_SAT      = 16'hFFFF;

    // one character transfer as queued for the driver
    typedef struct packed {
        logic [7:0] code;
        logic       fin;      // last character of its text
        logic       drain;    // hold back until all tokens are in
    } char_item_t;

    // one token as it should appear on token_out
    typedef struct {
        kind_t       kind;
        logic [15:0] s_pos;
        logic [15:0] e_pos;
        logic        run_last;
    } tok_rec_t;

    // receiver stall patterns, picked at random and switched periodically
    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HALF,
        RX_SPARSE
    } rx_pattern_t;

    logic clk;
    logic rst_n;

    pts_in_if  char_bus ();
    pts_out_if tok_bus ();

    polynomial_token_scanner_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_bus),
        .token_out (tok_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scanner predictor: its own mode, next position and monomial start.
    // ------------------------------------------------------------------------
    mode_t       scan_st;
    logic [15:0] next_pos;
    logic [15:0] tok_begin;

    tok_rec_t    step_toks [0:3];   // tokens caused by the current character
    int          step_cnt;
    tok_rec_t    tokens_due [$];    // tokens still owed by the unit

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic note_token(input kind_t k, input logic [15:0] s, input logic [15:0] e);
        step_toks[step_cnt].kind     = k;
        step_toks[step_cnt].s_pos    = s;
        step_toks[step_cnt].e_pos    = e;
        step_toks[step_cnt].run_last = 1'b0;
        step_cnt++;
    endtask

    task automatic tokenize_char(input logic [7:0] c, input logic fin);
        logic [15:0] p;
        bit          rescan;
        bit          in_token;

        p        = next_pos;
        step_cnt = 0;
        in_token = scan_st >= MODE_INT && scan_st <= MODE_EXP;

        if (scan_st == MODE_DROP)
        begin
            // everything up to the last flag is swallowed
        end
        else if (p == POS_SAT)
        begin
            // saturated position: pending monomial is lost, error instead
            note_token(KIND_ERROR, in_token ? tok_begin : POS_SAT, POS_SAT);
            scan_st = MODE_DROP;
        end
        else
        begin
            // a character that closes a monomial is scanned again from idle
            rescan = 1'b1;
            while (rescan)
            begin
                rescan = 1'b0;
                case (scan_st)
                    MODE_IDLE:
                    begin
                        if (is_blank(c))
                        begin
                        end
                        else if (c == CH_LPAREN) note_token(KIND_LPAREN, p, p + 16'd1);
                        else if (c == CH_RPAREN) note_token(KIND_RPAREN, p, p + 16'd1);
                        else if (c == CH_PLUS)   note_token(KIND_PLUS, p, p + 16'd1);
                        else if (c == CH_MINUS)  note_token(KIND_MINUS, p, p + 16'd1);
                        else if (c == CH_STAR)   note_token(KIND_STAR, p, p + 16'd1);
                        else if (c == CH_X)
                        begin
                            tok_begin = p;
                            scan_st   = MODE_VAR;
                        end
                        else if (is_num(c))
                        begin
                            tok_begin = p;
                            scan_st   = MODE_INT;
                        end
                        else if (c == CH_DOT)
                        begin
                            tok_begin = p;
                            scan_st   = MODE_FRAC;
                        end
                        else
                        begin
                            note_token(KIND_ERROR, p, p + 16'd1);
                            scan_st = MODE_DROP;
                        end
                    end
                    MODE_INT, MODE_FRAC:
                    begin
                        if (is_num(c))
                        begin
                        end
                        else if (c == CH_DOT && scan_st == MODE_INT) scan_st = MODE_FRAC;
                        else if (c == CH_X) scan_st = MODE_VAR;
                        else
                        begin
                            note_token(KIND_MONO, tok_begin, p);
                            scan_st = MODE_IDLE;
                            rescan  = 1'b1;
                        end
                    end
                    MODE_VAR:
                    begin
                        if (c == CH_CARET) scan_st = MODE_CARET;
                        else
                        begin
                            note_token(KIND_MONO, tok_begin, p);
                            scan_st = MODE_IDLE;
                            rescan  = 1'b1;
                        end
                    end
                    MODE_CARET:
                    begin
                        // blank right after the caret spans the whole monomial
                        if (is_blank(c))
                        begin
                            note_token(KIND_ERROR, tok_begin, p + 16'd1);
                            scan_st = MODE_DROP;
                        end
                        else if (is_num(c)) scan_st = MODE_EXP;
                        else
                        begin
                            note_token(KIND_MONO, tok_begin, p);
                            scan_st = MODE_IDLE;
                            rescan  = 1'b1;
                        end
                    end
                    MODE_EXP:
                    begin
                        if (!is_num(c))
                        begin
                            note_token(KIND_MONO, tok_begin, p);
                            scan_st = MODE_IDLE;
                            rescan  = 1'b1;
                        end
                    end
                    default: scan_st = MODE_DROP;
                endcase
            end

            // last character closes any monomial, then the end token
            if (fin && scan_st != MODE_DROP)
            begin
                if (scan_st >= MODE_INT && scan_st <= MODE_EXP)
                    note_token(KIND_MONO, tok_begin, p + 16'd1);
                note_token(KIND_END, p + 16'd1, p + 16'd1);
            end
        end

        if (fin)
        begin
            scan_st   = MODE_IDLE;
            next_pos  = '0;
            tok_begin = '0;
        end
        else if (next_pos != POS_SAT)
        begin
            next_pos = next_pos + 16'd1;
        end

        if (step_cnt > 0)
            step_toks[step_cnt - 1].run_last = 1'b1;
        for (int i = 0; i < step_cnt; i++)
            tokens_due.insert(tokens_due.size(), step_toks[i]);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus texts
    // ------------------------------------------------------------------------
    char_item_t  chars_pending [$];
    logic [7:0]  text_buf [$];
    int          total_chars;

    // hand the text in text_buf to the driver; last flag on its final char
    task automatic flush_text(input bit drain);
        char_item_t item;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            item.code  = text_buf[i];
            item.fin   = (i == text_buf.size() - 1);
            item.drain = drain && (i == 0);
            chars_pending.insert(chars_pending.size(), item);
            total_chars++;
        end
        text_buf.delete();
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.insert(text_buf.size(), s[i]);
    endtask

    task automatic put_digits(input int n);
        for (int i = 0; i < n; i++)
            text_buf.insert(text_buf.size(), CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic put_blanks(input int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 5);
            text_buf.insert(text_buf.size(), pick == 5 ? CH_SPACE : CH_TAB + 8'(pick));
        end
    endtask

    task automatic put_monomial();
        int nd;
        nd = $urandom_range(0, 3);
        put_digits(nd);
        if (nd > 0 && $urandom_range(0, 2) == 0)
        begin
            text_buf.insert(text_buf.size(), CH_DOT);
            put_digits($urandom_range(0, 2));
        end
        if (nd == 0 && $urandom_range(0, 5) == 0)
        begin
            text_buf.insert(text_buf.size(), CH_DOT);   // lone dot is a monomial too
        end
        else if (nd == 0 || $urandom_range(0, 1) == 1)
        begin
            text_buf.insert(text_buf.size(), CH_X);
            if ($urandom_range(0, 1) == 1)
            begin
                text_buf.insert(text_buf.size(), CH_CARET);
                if ($urandom_range(0, 9) == 0)
                    put_blanks(1);        // blank after caret: error
                else
                    put_digits($urandom_range(0, 2));
            end
        end
    endtask

    task automatic put_expression();
        int nterms;
        int op;
        nterms = $urandom_range(1, 4);
        for (int i = 0; i < nterms; i++)
        begin
            if (i > 0)
            begin
                op = $urandom_range(0, 2);
                text_buf.insert(text_buf.size(),
                                op == 0 ? CH_PLUS : (op == 1 ? CH_MINUS : CH_STAR));
            end
            put_blanks($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
            if ($urandom_range(0, 4) == 0) text_buf.insert(text_buf.size(), CH_LPAREN);
            put_monomial();
            if ($urandom_range(0, 4) == 0) text_buf.insert(text_buf.size(), CH_RPAREN);
            put_blanks($urandom_range(0, 3) == 0 ? 1 : 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of random length, random gaps between them. An item
    // flagged drain waits with valid low until every token has come back.
    // ------------------------------------------------------------------------
    char_item_t next_char;
    int         burst_left;
    int         gap_left;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            char_bus.valid     <= 1'b0;
            char_bus.char_code <= '0;
            char_bus.last_char <= 1'b0;
            burst_left         <= 1;
            gap_left           <= 0;
        end
        else if (!char_bus.valid || char_bus.ready)
        begin
            if (gap_left > 0)
            begin
                char_bus.valid <= 1'b0;
                gap_left       <= gap_left - 1;
            end
            else if (chars_pending.size() != 0 &&
                     (!chars_pending[0].drain ||
                      (!char_bus.valid && tokens_due.size() == 0)))
            begin
                next_char           = chars_pending.pop_front();
                char_bus.valid     <= 1'b1;
                char_bus.char_code <= next_char.code;
                char_bus.last_char <= next_char.fin;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                char_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern changes periodically; once, a long hold-off
    // so the result queue fills and char_in backs up.
    // ------------------------------------------------------------------------
    rx_pattern_t rx_pattern;
    int          rx_phase;
    int          hold_left;
    bit          long_hold_done;
    int          chars_taken;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tok_bus.ready  <= 1'b0;
            rx_pattern     <= RX_OPEN;
            rx_phase       <= 0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            rx_phase <= rx_phase + 1;
            if (rx_phase % 48 == 47)
                rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
            if (hold_left != 0)
            begin
                tok_bus.ready <= 1'b0;
                hold_left     <= hold_left - 1;
            end
            else if (!long_hold_done && chars_taken >= 80)
            begin
                tok_bus.ready  <= 1'b0;
                hold_left      <= 200;
                long_hold_done <= 1'b1;
            end
            else
            begin
                case (rx_pattern)
                    RX_OPEN:  tok_bus.ready <= 1'b1;
                    RX_LIGHT: tok_bus.ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:  tok_bus.ready <= ($urandom_range(0, 1) == 1);
                    default:  tok_bus.ready <= (rx_phase % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check the token transfer against the oldest expectation first,
    // then predict for the character transferred at the same edge.
    // ------------------------------------------------------------------------
    tok_rec_t want;
    int       fail_count;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tok_bus.valid && tok_bus.ready)
            begin
                if (tokens_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("token with none expected: kind %0d start %0d end %0d last %0d",
                                 tok_bus.kind, tok_bus.start_pos, tok_bus.end_pos,
                                 tok_bus.run_last);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (tok_bus.kind !== want.kind || tok_bus.start_pos !== want.s_pos ||
                        tok_bus.end_pos !== want.e_pos || tok_bus.run_last !== want.run_last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("token mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                     want.kind, want.s_pos, want.e_pos, want.run_last,
                                     tok_bus.kind, tok_bus.start_pos, tok_bus.end_pos,
                                     tok_bus.run_last);
                    end
                end
            end
            if (char_bus.valid && char_bus.ready)
            begin
                tokenize_char(char_bus.char_code, char_bus.last_char);
                chars_taken <= chars_taken + 1;
            end
        end
    end

    // watchdog
    int cycle_cnt;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("polynomial_token_scanner_unit_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int random_chars;
        int pick;

        clk                = 1'b0;
        rst_n              = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = '0;
        char_bus.last_char = 1'b0;
        tok_bus.ready      = 1'b0;
        scan_st            = MODE_IDLE;
        next_pos           = '0;
        tok_begin          = '0;
        total_chars        = 0;
        chars_taken        = 0;
        fail_count         = 0;
        cycle_cnt          = 0;

        // directed: parens, minus and star, full monomial, three tokens at last
        add_str("(3.5x^12-x)*2)");
        flush_text(1'b0);
        // blank after caret, rest dropped
        add_str("x^ 7");
        flush_text(1'b0);
        // upper-case X starts nothing; error on the last char, no end token
        add_str("X");
        flush_text(1'b0);
        // byte extremes: 0xFF errors, the rest dropped up to the last flag
        text_buf.insert(text_buf.size(), 8'hFF);
        text_buf.insert(text_buf.size(), CH_PLUS);
        text_buf.insert(text_buf.size(), 8'h00);
        flush_text(1'b0);
        // tab skipped, lone dot closed by lookahead
        add_str("\t.+");
        flush_text(1'b0);
        // dangling caret closed by the last flag
        add_str(".x^");
        flush_text(1'b0);

        // random: mostly well-formed expressions, some broken, some noise
        random_chars = 0;
        while (random_chars < RANDOM_CHARS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 9)
            begin
                put_expression();
                if (pick >= 7)
                    text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
            end
            random_chars += text_buf.size();
            flush_text(random_chars == text_buf.size() || $urandom_range(0, 11) == 0);
        end

        // short text after a drain: positions restart at zero
        add_str("2x^3");
        flush_text(1'b1);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (chars_taken != total_chars)
            @(posedge clk);
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0)
            $display("polynomial_token_scanner_unit_tb passed");
        else
            $display("polynomial_token_scanner_unit_tb failed");
        $finish;
    end

endmodule : polynomial_token_scanner_unit_tb
